// ===== rtl/rae_pkg.sv =====
// shared types and opcode constants for the risc alu execute step
// no dependencies
package rae_pkg;

    localparam int DataWidth   = 32;
    localparam int KindWidth   = 5;
    localparam int ShiftWidth  = 5;
    localparam int WordAddrLsb = 2;
    localparam int LuiShift    = 16;

    // opcodes
    localparam logic [KindWidth-1:0] OP_ADD  = 5'd0;
    localparam logic [KindWidth-1:0] OP_SUB  = 5'd1;
    localparam logic [KindWidth-1:0] OP_AND  = 5'd2;
    localparam logic [KindWidth-1:0] OP_OR   = 5'd3;
    localparam logic [KindWidth-1:0] OP_XOR  = 5'd4;
    localparam logic [KindWidth-1:0] OP_NOR  = 5'd5;
    localparam logic [KindWidth-1:0] OP_SLL  = 5'd6;
    localparam logic [KindWidth-1:0] OP_SRL  = 5'd7;
    localparam logic [KindWidth-1:0] OP_SLT  = 5'd8;
    localparam logic [KindWidth-1:0] OP_JR   = 5'd9;
    localparam logic [KindWidth-1:0] OP_J    = 5'd10;
    localparam logic [KindWidth-1:0] OP_JAL  = 5'd11;
    localparam logic [KindWidth-1:0] OP_LW   = 5'd12;
    localparam logic [KindWidth-1:0] OP_SW   = 5'd13;
    localparam logic [KindWidth-1:0] OP_LI   = 5'd14;
    localparam logic [KindWidth-1:0] OP_BEQ  = 5'd15;
    localparam logic [KindWidth-1:0] OP_BNE  = 5'd16;
    localparam logic [KindWidth-1:0] OP_LUI  = 5'd17;
    localparam logic [KindWidth-1:0] OP_SLTI = 5'd18;
    localparam logic [KindWidth-1:0] OP_ADDI = 5'd19;
    localparam logic [KindWidth-1:0] OP_ANDI = 5'd20;
    localparam logic [KindWidth-1:0] OP_ORI  = 5'd21;
    localparam logic [KindWidth-1:0] OP_XORI = 5'd22;

    // one decoded instruction with its operands
    typedef struct packed {
        logic [KindWidth-1:0]         kind;
        logic signed [DataWidth-1:0]  src_a;
        logic signed [DataWidth-1:0]  src_b;
        logic signed [DataWidth-1:0]  immediate;
        logic [ShiftWidth-1:0]        shift_amount;
        logic [DataWidth-1:0]         instr_address;
        logic [DataWidth-1:0]         jump_target;
    } rae_item_t;

    // one execute result
    typedef struct packed {
        logic                                write_enable;
        logic                                write_link;
        logic signed [DataWidth-1:0]         write_value;
        logic                                redirect;
        logic [DataWidth-1:0]                new_pc;
        logic                                mem_read;
        logic                                mem_write;
        logic [DataWidth-WordAddrLsb-1:0]    mem_word_address;
        logic signed [DataWidth-1:0]         store_value;
        logic                                operands_equal;
    } rae_result_t;

endpackage

// ===== rtl/risc_alu_execute_step.sv =====
// top level of the risc alu execute step: input stage, alu and result register
// depends on rae_pkg, rae_in_stage and rae_alu
//
// Execute stage for a 32-bit RISC integer subset. Each accepted request carries an
// opcode and its operands and yields exactly one result: a register write-back, a
// program counter redirect and/or a word-addressed load or store request. Unused
// opcodes give an all-zero result. Requests flow through two registers, an input
// register and a result register, with the alu logic between them, and one request
// can be accepted every cycle while the output is not stalled. A stall on the output
// fills the two registers and then stalls the input. There is no state besides the
// pipeline.
module risc_alu_execute_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         kind,
    input  logic signed [31:0] src_a,
    input  logic signed [31:0] src_b,
    input  logic signed [31:0] immediate,
    input  logic [4:0]         shift_amount,
    input  logic [31:0]        instr_address,
    input  logic [31:0]        jump_target,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               write_enable,
    output logic               write_link,
    output logic signed [31:0] write_value,
    output logic               redirect,
    output logic [31:0]        new_pc,
    output logic               mem_read,
    output logic               mem_write,
    output logic [29:0]        mem_word_address,
    output logic signed [31:0] store_value,
    output logic               operands_equal
);
    import rae_pkg::*;

    rae_item_t   in_item;
    rae_item_t   held_item;
    logic        held_valid;
    logic        held_take;
    rae_result_t alu_result;
    rae_result_t result_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        result_load;

    // gather input fields
    always_comb
    begin
        in_item.kind          = kind;
        in_item.src_a         = src_a;
        in_item.src_b         = src_b;
        in_item.immediate     = immediate;
        in_item.shift_amount  = shift_amount;
        in_item.instr_address = instr_address;
        in_item.jump_target   = jump_target;
    end

    rae_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_take  (held_take),
        .held_item  (held_item)
    );

    rae_alu u_alu (
        .item   (held_item),
        .result (alu_result)
    );

    // result register moves when empty or when its content is taken
    assign result_load = !out_valid_reg || !out_stall;
    assign held_take   = result_load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = held_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload capture
    always_ff @(posedge clk)
    begin
        if (result_load && held_valid)
        begin
            result_reg <= alu_result;
        end
    end

    // output fields
    assign out_valid        = out_valid_reg;
    assign write_enable     = result_reg.write_enable;
    assign write_link       = result_reg.write_link;
    assign write_value      = result_reg.write_value;
    assign redirect         = result_reg.redirect;
    assign new_pc           = result_reg.new_pc;
    assign mem_read         = result_reg.mem_read;
    assign mem_write        = result_reg.mem_write;
    assign mem_word_address = result_reg.mem_word_address;
    assign store_value      = result_reg.store_value;
    assign operands_equal   = result_reg.operands_equal;

endmodule

// ===== rtl/rae_in_stage.sv =====
// input register stage: holds one accepted request until the result stage takes it
// depends on rae_pkg
module rae_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rae_pkg::rae_item_t in_item,
    output logic               held_valid,
    input  logic               held_take,
    output rae_pkg::rae_item_t held_item
);
    import rae_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    rae_item_t item_reg;
    logic      load;

    // stall only while holding a request that cannot move on
    assign in_stall = valid_reg && !held_take;
    assign load     = in_valid && !in_stall;

    // valid bit follows load and take
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (held_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== rtl/rae_alu.sv =====
// combinational execute logic: alu, branch decision and memory request
// depends on rae_pkg
module rae_alu (
    input  rae_pkg::rae_item_t   item,
    output rae_pkg::rae_result_t result
);
    import rae_pkg::*;

    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    logic [DataWidth-1:0] imm;
    logic [DataWidth-1:0] mem_sum;
    logic                 a_eq_b;
    logic                 a_eq_imm;

    assign a        = item.src_a;
    assign b        = item.src_b;
    assign imm      = item.immediate;
    assign mem_sum  = a + imm;
    assign a_eq_b   = (a == b);
    assign a_eq_imm = (a == imm);

    // opcode decode, every field zero unless the opcode sets it
    always_comb
    begin
        result = '0;
        case (item.kind)
            OP_ADD:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a + b;
            end
            OP_SUB:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a - b;
            end
            OP_AND:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a & b;
            end
            OP_OR:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a | b;
            end
            OP_XOR:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a ^ b;
            end
            OP_NOR:
            begin
                result.write_enable = 1'b1;
                result.write_value  = ~(a | b);
            end
            OP_SLL:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a << item.shift_amount;
            end
            OP_SRL:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a >> item.shift_amount;
            end
            OP_SLT:
            begin
                result.write_enable   = 1'b1;
                result.write_value    = {{(DataWidth-1){1'b0}},
                                         (item.src_a < item.src_b)};
                result.operands_equal = a_eq_b;
            end
            OP_JR:
            begin
                result.redirect = 1'b1;
                result.new_pc   = a;
            end
            OP_J:
            begin
                result.redirect = 1'b1;
                result.new_pc   = item.jump_target;
            end
            OP_JAL:
            begin
                result.redirect     = 1'b1;
                result.new_pc       = item.jump_target;
                result.write_enable = 1'b1;
                result.write_link   = 1'b1;
                result.write_value  = item.instr_address;
            end
            OP_LW:
            begin
                result.mem_read         = 1'b1;
                result.mem_word_address = mem_sum[DataWidth-1:WordAddrLsb];
            end
            OP_SW:
            begin
                result.mem_write        = 1'b1;
                result.mem_word_address = mem_sum[DataWidth-1:WordAddrLsb];
                result.store_value      = item.src_b;
            end
            OP_LI:
            begin
                result.write_enable = 1'b1;
                result.write_value  = imm;
            end
            OP_BEQ:
            begin
                if (a_eq_b)
                begin
                    result.operands_equal = 1'b1;
                    result.redirect       = 1'b1;
                    result.new_pc         = item.jump_target;
                end
            end
            OP_BNE:
            begin
                if (!a_eq_b)
                begin
                    result.redirect = 1'b1;
                    result.new_pc   = item.jump_target;
                end
            end
            OP_LUI:
            begin
                result.write_enable = 1'b1;
                result.write_value  = imm << LuiShift;
            end
            OP_SLTI:
            begin
                result.write_enable   = 1'b1;
                result.write_value    = {{(DataWidth-1){1'b0}},
                                         (item.src_a < item.immediate)};
                result.operands_equal = a_eq_imm;
            end
            OP_ADDI:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a + imm;
            end
            OP_ANDI:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a & imm;
            end
            OP_ORI:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a | imm;
            end
            OP_XORI:
            begin
                result.write_enable = 1'b1;
                result.write_value  = a ^ imm;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

// ===== sim/risc_alu_execute_step_tb.sv =====
// testbench for risc_alu_execute_step: directed and random requests checked by a predictor
// depends on rae_pkg and the risc_alu_execute_step rtl
module risc_alu_execute_step_tb;

    import rae_pkg::*;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // request side
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [4:0]         kind = '0;
    logic signed [31:0] src_a = '0;
    logic signed [31:0] src_b = '0;
    logic signed [31:0] immediate = '0;
    logic [4:0]         shift_amount = '0;
    logic [31:0]        instr_address = '0;
    logic [31:0]        jump_target = '0;

    // result side
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               write_enable;
    logic               write_link;
    logic signed [31:0] write_value;
    logic               redirect;
    logic [31:0]        new_pc;
    logic               mem_read;
    logic               mem_write;
    logic [29:0]        mem_word_address;
    logic signed [31:0] store_value;
    logic               operands_equal;

    // run bookkeeping
    rae_result_t pending_results[$];
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    bit          send_gaps = 1'b0;
    bit          stall_random = 1'b0;
    int          hold_request = 0;
    int          hold_left = 0;

    risc_alu_execute_step u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .src_a            (src_a),
        .src_b            (src_b),
        .immediate        (immediate),
        .shift_amount     (shift_amount),
        .instr_address    (instr_address),
        .jump_target      (jump_target),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .write_enable     (write_enable),
        .write_link       (write_link),
        .write_value      (write_value),
        .redirect         (redirect),
        .new_pc           (new_pc),
        .mem_read         (mem_read),
        .mem_write        (mem_write),
        .mem_word_address (mem_word_address),
        .store_value      (store_value),
        .operands_equal   (operands_equal)
    );

    // expected execute result for one instruction
    function automatic rae_result_t predict_execute(input rae_item_t req);
        rae_result_t res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [31:0] byte_addr;
        a = req.src_a;
        b = req.src_b;
        imm = req.immediate;
        byte_addr = a + imm;
        res = '0;
        case (req.kind)
            OP_ADD:  begin res.write_enable = 1'b1; res.write_value = a + b; end
            OP_SUB:  begin res.write_enable = 1'b1; res.write_value = a - b; end
            OP_AND:  begin res.write_enable = 1'b1; res.write_value = a & b; end
            OP_OR:   begin res.write_enable = 1'b1; res.write_value = a | b; end
            OP_XOR:  begin res.write_enable = 1'b1; res.write_value = a ^ b; end
            OP_NOR:  begin res.write_enable = 1'b1; res.write_value = ~(a | b); end
            OP_SLL:
            begin
                res.write_enable = 1'b1;
                res.write_value = a << req.shift_amount;
            end
            OP_SRL:
            begin
                res.write_enable = 1'b1;
                res.write_value = a >> req.shift_amount;
            end
            OP_SLT:
            begin
                res.write_enable = 1'b1;
                res.write_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                res.operands_equal = (a == b);
            end
            OP_JR:   begin res.redirect = 1'b1; res.new_pc = a; end
            OP_J:    begin res.redirect = 1'b1; res.new_pc = req.jump_target; end
            OP_JAL:
            begin
                res.redirect = 1'b1;
                res.new_pc = req.jump_target;
                res.write_enable = 1'b1;
                res.write_link = 1'b1;
                res.write_value = req.instr_address;
            end
            // load: only the memory request, write-back comes from memory
            OP_LW:
            begin
                res.mem_read = 1'b1;
                res.mem_word_address = byte_addr[31:WordAddrLsb];
            end
            OP_SW:
            begin
                res.mem_write = 1'b1;
                res.mem_word_address = byte_addr[31:WordAddrLsb];
                res.store_value = b;
            end
            OP_LI:   begin res.write_enable = 1'b1; res.write_value = imm; end
            OP_BEQ:
            begin
                if (a == b)
                begin
                    res.operands_equal = 1'b1;
                    res.redirect = 1'b1;
                    res.new_pc = req.jump_target;
                end
            end
            OP_BNE:
            begin
                if (a != b)
                begin
                    res.redirect = 1'b1;
                    res.new_pc = req.jump_target;
                end
            end
            OP_LUI:  begin res.write_enable = 1'b1; res.write_value = imm << LuiShift; end
            OP_SLTI:
            begin
                res.write_enable = 1'b1;
                res.write_value = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
                res.operands_equal = (a == imm);
            end
            OP_ADDI: begin res.write_enable = 1'b1; res.write_value = a + imm; end
            OP_ANDI: begin res.write_enable = 1'b1; res.write_value = a & imm; end
            OP_ORI:  begin res.write_enable = 1'b1; res.write_value = a | imm; end
            OP_XORI: begin res.write_enable = 1'b1; res.write_value = a ^ imm; end
            default: res = '0;
        endcase
        return res;
    endfunction

    // operand values weighted toward the corners
    function automatic logic [31:0] operand_value();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            4: return $urandom_range(15);
            5: return -$urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // random instruction, optionally biased toward compares, jumps and memory ops
    function automatic rae_item_t random_request(input bit branchy);
        rae_item_t r;
        if (branchy)
        begin
            case ($urandom_range(8))
                0: r.kind = OP_SLT;
                1: r.kind = OP_SLTI;
                2: r.kind = OP_BEQ;
                3: r.kind = OP_BNE;
                4: r.kind = OP_JR;
                5: r.kind = OP_J;
                6: r.kind = OP_JAL;
                7: r.kind = OP_LW;
                default: r.kind = OP_SW;
            endcase
        end
        else if ($urandom_range(19) == 0)
            r.kind = 5'($urandom_range(31, OP_XORI + 1));
        else
            r.kind = 5'($urandom_range(OP_XORI));
        r.src_a = operand_value();
        r.src_b = operand_value();
        r.immediate = operand_value();
        r.shift_amount = 5'($urandom_range(31));
        r.instr_address = $urandom;
        r.jump_target = $urandom;
        // equal operands so compares and branches take both paths
        if ($urandom_range(branchy ? 1 : 5) == 0)
            r.src_b = r.src_a;
        if ($urandom_range(branchy ? 1 : 5) == 0)
            r.immediate = r.src_a;
        return r;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // drive one request and wait until it is taken; called and returns at a falling edge
    task automatic send_request(input rae_item_t req);
        while (send_gaps && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= req.kind;
        src_a         <= req.src_a;
        src_b         <= req.src_b;
        immediate     <= req.immediate;
        shift_amount  <= req.shift_amount;
        instr_address <= req.instr_address;
        jump_target   <= req.jump_target;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_execute(req));
        n_sent++;
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        rae_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                compare_field("write_enable", 32'(write_enable), 32'(want.write_enable));
                compare_field("write_link", 32'(write_link), 32'(want.write_link));
                compare_field("write_value", write_value, want.write_value);
                compare_field("redirect", 32'(redirect), 32'(want.redirect));
                compare_field("new_pc", new_pc, want.new_pc);
                compare_field("mem_read", 32'(mem_read), 32'(want.mem_read));
                compare_field("mem_write", 32'(mem_write), 32'(want.mem_write));
                compare_field("mem_word_address", 32'(mem_word_address),
                              32'(want.mem_word_address));
                compare_field("store_value", store_value, want.store_value);
                compare_field("operands_equal", 32'(operands_equal),
                              32'(want.operands_equal));
                n_checked++;
            end
        end
    end

    // output stall: long hold-off when requested, else random or none
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (stall_random)
            out_stall <= ($urandom_range(99) < 30);
        else
            out_stall <= 1'b0;
    end

    // every opcode at the corners plus branch, compare and unused-code cases
    task automatic test_directed_ops();
        rae_item_t r;
        send_gaps = 1'b0;
        stall_random = 1'b0;
        r.src_a = 32'h8000_0000;
        r.src_b = 32'h7fff_ffff;
        r.immediate = 32'hffff_ffff;
        r.shift_amount = 5'd31;
        r.instr_address = 32'hffff_fffc;
        r.jump_target = 32'hffff_ffff;
        for (int k = OP_ADD; k <= OP_XORI; k++)
        begin
            r.kind = 5'(k);
            send_request(r);
        end
        // branch equal taken, branch not-equal not taken, compares on equal operands
        r.src_a = 32'hffff_ffff;
        r.src_b = 32'hffff_ffff;
        r.immediate = 32'hffff_ffff;
        r.shift_amount = 5'd0;
        r.instr_address = 32'h0000_0000;
        r.jump_target = 32'h0000_0004;
        r.kind = OP_BEQ;
        send_request(r);
        r.kind = OP_BNE;
        send_request(r);
        r.kind = OP_SLT;
        send_request(r);
        r.kind = OP_SLTI;
        send_request(r);
        // unused opcodes give an all-zero result
        r.kind = 5'(OP_XORI + 1);
        send_request(r);
        r.kind = 5'h1f;
        send_request(r);
    endtask

    // bulk random mix with idling on both sides
    task automatic test_random_ops(input int count);
        send_gaps = 1'b1;
        stall_random = 1'b1;
        repeat (count)
            send_request(random_request(1'b0));
    endtask

    // compares, branches, jumps and memory ops with many equal operands
    task automatic test_compare_branch(input int count);
        send_gaps = 1'b1;
        stall_random = 1'b1;
        repeat (count)
            send_request(random_request(1'b1));
    endtask

    // long stretch at full rate, no idling on either side
    task automatic test_back_to_back(input int count);
        send_gaps = 1'b0;
        stall_random = 1'b0;
        repeat (count)
            send_request(random_request(1'b0));
    endtask

    // receiver holds off while requests keep coming, so the input must stall
    task automatic test_backpressure(input int hold_cycles, input int count);
        send_gaps = 1'b0;
        stall_random = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        hold_request = hold_cycles;
        @(negedge clk);
        repeat (count)
            send_request(random_request(1'b0));
    endtask

    // main sequence
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_ops();
        test_random_ops(700);
        test_back_to_back(150);
        test_backpressure(60, 40);
        test_compare_branch(150);

        // drain
        in_valid <= 1'b0;
        send_gaps = 1'b0;
        stall_random = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("sent %0d requests, checked %0d results, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("all opcodes and unused codes, corner operands, random and held-off output");
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("watchdog expired with %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

endmodule

// ===== risc_alu_execute_step.f =====
rtl/rae_pkg.sv
rtl/rae_in_stage.sv
rtl/rae_alu.sv
rtl/risc_alu_execute_step.sv
sim/risc_alu_execute_step_tb.sv
